FILE: rtl/core/apfd_pkg.sv
`timescale 1ns / 1ps

package apfd_pkg;

  // Default build parameters
  localparam int LINE_DEPTH_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 16;

  // Register field widths
  localparam int WHOLE_W    = 12;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Multiplier coefficient operand: unsigned fraction or signed gain, one sign bit extra
  localparam int MUL_A_W = FRAC_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHOLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;

  localparam logic [WHOLE_W-1:0] WHOLE_RESET = 12'd1;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;      // load product register
    logic frac_shift;  // round by fraction bits, else by gain bits
    logic negate;      // subtract rounded product from addend
  } mac_ctrl_t;

endpackage

FILE: rtl/core/apfd_ram.sv
`timescale 1ns / 1ps

module apfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/apfd_mac.sv
`timescale 1ns / 1ps

module apfd_mac #(
  parameter int SAMPLE_BITS   = apfd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = apfd_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  apfd_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [apfd_pkg::MUL_A_W-1:0] mul_a_i,
  input  logic signed [SAMPLE_BITS:0]         mul_b_i,
  input  logic signed [SAMPLE_BITS:0]         addend_i,
  output logic signed [SAMPLE_BITS-1:0]       result_o
);

  localparam int PW = apfd_pkg::MUL_A_W + SAMPLE_BITS + 1;

  localparam logic signed [PW:0] HALF_F = (PW+1)'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [PW:0] HALF_G = (PW+1)'(1) <<< (apfd_pkg::GAIN_FRAC - 1);
  localparam logic signed [PW+1:0] SAT_HI = (PW+2)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW+1:0] SAT_LO = -SAT_HI - (PW+2)'(1);

  logic signed [PW-1:0] prod_q;
  logic signed [PW:0]   prod_ext;
  logic signed [PW:0]   sum_f;
  logic signed [PW:0]   sum_g;
  logic signed [PW:0]   rnd;
  logic signed [PW+1:0] total;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a_i * mul_b_i;
    end
  end

  // round half up, then floor
  always_comb begin
    prod_ext = {prod_q[PW-1], prod_q};
    sum_f    = prod_ext + HALF_F;
    sum_g    = prod_ext + HALF_G;
    rnd      = ctrl_i.frac_shift ? (sum_f >>> FRACTION_BITS)
                                 : (sum_g >>> apfd_pkg::GAIN_FRAC);
    if (ctrl_i.negate) begin
      total = (PW+2)'(addend_i) - (PW+2)'(rnd);
    end else begin
      total = (PW+2)'(addend_i) + (PW+2)'(rnd);
    end
    if (total > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (total < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result_o = total[SAMPLE_BITS-1:0];
    end
  end

endmodule

FILE: rtl/core/apfd_seq.sv
`timescale 1ns / 1ps

module apfd_seq #(
  parameter int LINE_DEPTH    = apfd_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS   = apfd_pkg::SAMPLE_BITS_DEF,
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_i,
  input  logic [apfd_pkg::WHOLE_W-1:0]        whole_i,
  input  logic [apfd_pkg::FRAC_W-1:0]         frac_i,
  input  logic signed [apfd_pkg::GAIN_W-1:0]  gain_i,
  input  logic                                out_stall_i,
  output logic                                res_valid_o,
  output logic signed [SAMPLE_BITS-1:0]       res_sample_o,
  output logic [AW-1:0]                       ram_raddr_o,
  input  logic [SAMPLE_BITS-1:0]              ram_rdata_i,
  output logic                                ram_we_o,
  output logic [AW-1:0]                       ram_waddr_o,
  output logic [SAMPLE_BITS-1:0]              ram_wdata_o,
  output apfd_pkg::mac_ctrl_t                 mac_ctrl_o,
  output logic signed [apfd_pkg::MUL_A_W-1:0] mac_a_o,
  output logic signed [SAMPLE_BITS:0]         mac_b_o,
  output logic signed [SAMPLE_BITS:0]         mac_addend_o,
  input  logic signed [SAMPLE_BITS-1:0]       mac_result_i
);

  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int CW    = (CNT_W > apfd_pkg::WHOLE_W) ? CNT_W : apfd_pkg::WHOLE_W;
  localparam int IW    = CNT_W + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD2  = 4'd1;
  localparam logic [3:0] ST_DIFF = 4'd2;
  localparam logic [3:0] ST_M1   = 4'd3;
  localparam logic [3:0] ST_A1   = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_A2   = 4'd6;
  localparam logic [3:0] ST_M3   = 4'd7;
  localparam logic [3:0] ST_A3   = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    wr_q, wr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             have_tap_q, have_d2_q;
  logic [AW-1:0]    idx2_q;
  logic signed [SAMPLE_BITS-1:0] x_q, d1_q, value_q, dwr_q;
  logic signed [SAMPLE_BITS:0]   diff_q;

  logic [CW-1:0]    whole_ext;
  logic [CNT_W-1:0] whole_eff;
  logic [CNT_W-1:0] whole_p1;
  logic             accept;
  logic signed [SAMPLE_BITS-1:0] d2;

  function automatic logic [AW-1:0] tap_idx(input logic [AW-1:0] wr,
                                            input logic [CNT_W-1:0] back);
    logic [IW-1:0] t;
    t = IW'(wr) + IW'(LINE_DEPTH) - IW'(back);
    if (t >= IW'(LINE_DEPTH)) begin
      t = t - IW'(LINE_DEPTH);
    end
    return t[AW-1:0];
  endfunction

  // whole delay clamped to 1 .. LINE_DEPTH-1
  always_comb begin
    whole_ext = CW'(whole_i);
    if (whole_ext == '0) begin
      whole_eff = CNT_W'(1);
    end else if (whole_ext > CW'(LINE_DEPTH - 1)) begin
      whole_eff = CNT_W'(LINE_DEPTH - 1);
    end else begin
      whole_eff = whole_ext[CNT_W-1:0];
    end
    whole_p1 = whole_eff + CNT_W'(1);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign d2         = have_d2_q ? $signed(ram_rdata_i) : '0;

  assign ram_raddr_o  = (state_q == ST_IDLE) ? tap_idx(wr_q, whole_eff) : idx2_q;
  assign ram_we_o     = (state_q == ST_A2);
  assign ram_waddr_o  = wr_q;
  assign ram_wdata_o  = mac_result_i;
  assign res_valid_o  = (state_q == ST_A3) && !out_stall_i;
  assign res_sample_o = mac_result_i;

  always_comb begin
    state_d      = state_q;
    mac_ctrl_o   = '0;
    mac_a_o      = '0;
    mac_b_o      = '0;
    mac_addend_o = '0;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RD2;
      ST_RD2:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_M1;
      ST_M1: begin
        mac_ctrl_o.mul_en = 1'b1;
        mac_a_o = {1'b0, frac_i};
        mac_b_o = diff_q;
        state_d = ST_A1;
      end
      ST_A1: begin
        mac_ctrl_o.frac_shift = 1'b1;
        mac_addend_o = {d1_q[SAMPLE_BITS-1], d1_q};
        state_d = ST_M2;
      end
      ST_M2: begin
        mac_ctrl_o.mul_en = 1'b1;
        mac_a_o = {gain_i[apfd_pkg::GAIN_W-1], gain_i};
        mac_b_o = {value_q[SAMPLE_BITS-1], value_q};
        state_d = ST_A2;
      end
      ST_A2: begin
        mac_addend_o = {x_q[SAMPLE_BITS-1], x_q};
        state_d = ST_M3;
      end
      ST_M3: begin
        mac_ctrl_o.mul_en = 1'b1;
        mac_a_o = {gain_i[apfd_pkg::GAIN_W-1], gain_i};
        mac_b_o = {dwr_q[SAMPLE_BITS-1], dwr_q};
        state_d = ST_A3;
      end
      ST_A3: begin
        mac_ctrl_o.negate = 1'b1;
        mac_addend_o = {value_q[SAMPLE_BITS-1], value_q};
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (ram_we_o) begin
      wr_d = (wr_q == AW'(LINE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (cnt_q != CNT_W'(LINE_DEPTH)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q        <= in_sample_i;
      have_tap_q <= (cnt_q >= whole_eff);
      have_d2_q  <= (cnt_q > whole_eff);
      idx2_q     <= tap_idx(wr_q, whole_p1);
    end
    if (state_q == ST_RD2) d1_q <= $signed(ram_rdata_i);
    if (state_q == ST_DIFF) begin
      diff_q <= {d2[SAMPLE_BITS-1], d2} - {d1_q[SAMPLE_BITS-1], d1_q};
    end
    // start-up: no tap written yet, delayed value is zero
    if (state_q == ST_A1) value_q <= have_tap_q ? mac_result_i : '0;
    if (state_q == ST_A2) dwr_q <= mac_result_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LINE_DEPTH))
    else $error("written count beyond line depth");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IW'(wr_q) < IW'(LINE_DEPTH))
    else $error("write index beyond line depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == CNT_W'(LINE_DEPTH)))
    else $error("written count did not follow a store write");

  a_no_push_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !out_stall_i)
    else $error("result pushed into a full output register");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A3 && out_stall_i) |=> (state_q == ST_A3))
    else $error("final step left while output stalled");

endmodule

FILE: rtl/core/allpass_frac_delay_lerp_core.sv
`timescale 1ns / 1ps

// Allpass filter on a fractional delay line with linear interpolation.
// Input stream (s_axis_*): one signed sample per transfer. Output stream
// (m_axis_*): one filtered, saturated sample per input transfer, in order.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 whole delay, 1 fraction, 2 feedback gain); write only while idle.
// Timing: a transfer in is taken in the idle cycle, which also issues the
// newer tap read, then a sequencer runs eight steps over one shared
// multiplier (older tap read, difference, then three multiply/round-add
// pairs). m_axis_tvalid rises once the result of the last step is
// registered in the output register. A new input is taken only in idle, so
// the spacing between items is set by the idle cycle, the two tap steps and
// the three dependent multiplies through the single multiplier.
// A finished result sits in the output register; the next input is taken
// meanwhile. If the receiver stalls with that register full, the next
// result waits in its last step and s_axis_tready stays low.
// Reset: config to whole=1, fraction=0, gain=0; write index and fill count
// to zero. The delay store is not cleared; the fill count keeps unwritten
// entries from being used.
module allpass_frac_delay_lerp_core #(
  parameter int LINE_DEPTH    = apfd_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS   = apfd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = apfd_pkg::FRACTION_BITS_DEF,
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // [SAMPLE_BITS-1:0] in_sample
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata,  // [SAMPLE_BITS-1:0] out_sample
  // config write port
  input  logic                            cfg_we_i,
  input  logic [apfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [apfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(LINE_DEPTH);
  // only the low FRACTION_BITS of the fraction register take part
  localparam logic [apfd_pkg::FRAC_W-1:0] FRAC_MASK =
    (FRACTION_BITS >= apfd_pkg::FRAC_W) ? '1
                                        : apfd_pkg::FRAC_W'((1 << FRACTION_BITS) - 1);

  // configuration registers
  logic [apfd_pkg::WHOLE_W-1:0]       whole_q;
  logic [apfd_pkg::FRAC_W-1:0]        frac_q;
  logic signed [apfd_pkg::GAIN_W-1:0] gain_q;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]        out_data_q;
  logic                          out_stall;

  // sequencer <-> store / shared unit
  logic                                res_valid;
  logic signed [SAMPLE_BITS-1:0]       res_sample;
  logic [AW-1:0]                       ram_raddr, ram_waddr;
  logic [SAMPLE_BITS-1:0]              ram_rdata, ram_wdata;
  logic                                ram_we;
  apfd_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [apfd_pkg::MUL_A_W-1:0] mac_a;
  logic signed [SAMPLE_BITS:0]         mac_b, mac_addend;
  logic signed [SAMPLE_BITS-1:0]       mac_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q <= apfd_pkg::WHOLE_RESET;
      frac_q  <= '0;
      gain_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apfd_pkg::REG_WHOLE: whole_q <= cfg_data_i[apfd_pkg::WHOLE_W-1:0];
        apfd_pkg::REG_FRAC:  frac_q  <= cfg_data_i[apfd_pkg::FRAC_W-1:0] & FRAC_MASK;
        apfd_pkg::REG_GAIN:  gain_q  <= $signed(cfg_data_i[apfd_pkg::GAIN_W-1:0]);
        default: ;  // unused index, ignored
      endcase
    end
  end

  // output register: a full one that is not being taken holds the sequencer
  assign out_stall = out_valid_q && !m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (res_valid)     out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_data_q <= res_sample;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);

  apfd_seq #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .whole_i      (whole_q),
    .frac_i       (frac_q),
    .gain_i       (gain_q),
    .out_stall_i  (out_stall),
    .res_valid_o  (res_valid),
    .res_sample_o (res_sample),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .mac_ctrl_o   (mac_ctrl),
    .mac_a_o      (mac_a),
    .mac_b_o      (mac_b),
    .mac_addend_o (mac_addend),
    .mac_result_i (mac_result)
  );

  apfd_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .mul_a_i  (mac_a),
    .mul_b_i  (mac_b),
    .addend_i (mac_addend),
    .result_o (mac_result)
  );

  // delay store of feedback sums
  apfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
